// ----- rtl/psi_pkg.sv -----
// Shared constants, types and codes for the power spectrum integrator.
package psi_pkg;

    localparam int DEF_MAX_BINS    = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int ACC_BITS  = 48;
    localparam int OUT_BITS  = 32;
    localparam int CNT_BITS  = 16;
    localparam int BINS_BITS = 11;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 1;

    localparam logic [IDX_BITS-1:0] REG_BINS_IN_USE      = 1'd0;
    localparam logic [IDX_BITS-1:0] REG_SPECTRA_PER_DUMP = 1'd1;

    localparam logic [BINS_BITS-1:0] RST_BINS_IN_USE      = 11'd1024;
    localparam logic [CNT_BITS-1:0]  RST_SPECTRA_PER_DUMP = 16'd1024;

    typedef struct packed {
        logic                done;
        logic [OUT_BITS-1:0] quotient;
    } psi_div_res_t;

endpackage

// ----- rtl/psi_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module psi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/psi_divider.sv -----
// Bit-serial divider of a bin total by the period, saturating to 32 bits.
module psi_divider (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [psi_pkg::ACC_BITS-1:0]   dividend,
    input  logic [psi_pkg::CNT_BITS-1:0]   divisor,
    output psi_pkg::psi_div_res_t          res
);

    import psi_pkg::*;

    logic                busy_reg;
    logic                chk_reg;
    logic                done_reg;
    logic [4:0]          step_reg;
    logic [CNT_BITS-1:0] rem_reg;
    logic [OUT_BITS-1:0] low_reg;
    logic [CNT_BITS:0]   trial;
    logic                fits;

    assign trial = {rem_reg, low_reg[OUT_BITS-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            chk_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                chk_reg  <= 1'b1;
            end
            else if (busy_reg && chk_reg)
            begin
                chk_reg  <= 1'b0;
                step_reg <= 5'd31;
                if (rem_reg >= divisor)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 5'd1;
                if (step_reg == 5'd0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[ACC_BITS-1:OUT_BITS];
            low_reg <= dividend[OUT_BITS-1:0];
        end
        else if (busy_reg && chk_reg)
        begin
            if (rem_reg >= divisor)
            begin
                low_reg <= '1;
            end
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= CNT_BITS'(trial - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= trial[CNT_BITS-1:0];
            end
            low_reg <= {low_reg[OUT_BITS-2:0], fits};
        end
    end

    assign res.done     = done_reg;
    assign res.quotient = low_reg;

endmodule

// ----- rtl/power_spectrum_integrator.sv -----
// Power spectrum integrate-and-dump: per-bin power accumulation with averaged dump.
//
//  channel  dir  handshake         payload
//  s_*      in   tvalid / tready   tdata: sample_re, sample_im
//  m_*      out  tvalid / tready   tdata: out_word; tuser: is_count; tlast: last
//  cfg_*    in   cfg_we            cfg_index, cfg_wdata
//
// An item outside the final spectrum goes through accept and RAM read, squaring, then
// accumulate and write back through the single RAM port pair.
// In the final spectrum the bit-serial divider runs next, ending early when the average
// saturates; then the average is loaded into the output register, and on the
// last bin the count word is loaded after it.
// After reset a clearing pass writes zero to all MAX_BINS entries, one per cycle,
// before the first beat is accepted. A stalled output holds the block in its output
// state until the register frees; items without results keep flowing.
module power_spectrum_integrator #(
    parameter int MAX_BINS    = psi_pkg::DEF_MAX_BINS,
    parameter int SAMPLE_BITS = psi_pkg::DEF_SAMPLE_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // sample_re, sample_im
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_word
    output logic [psi_pkg::OUT_BITS-1:0]          m_tdata,
    // is_count
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast,
    input  logic                                  cfg_we,
    input  logic [psi_pkg::IDX_BITS-1:0]          cfg_index,
    input  logic [psi_pkg::CFG_BITS-1:0]          cfg_wdata
);

    import psi_pkg::*;

    localparam int PW = $clog2(MAX_BINS);
    localparam int NW = (PW + 1 > BINS_BITS) ? PW + 1 : BINS_BITS;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_ACC   = 7'b0001000,
        S_DIV   = 7'b0010000,
        S_OUT   = 7'b0100000,
        S_CNT   = 7'b1000000
    } state_t;

    state_t                         state_reg;
    logic [PW-1:0]                  clr_reg;
    logic [PW-1:0]                  pos_reg;
    logic [CNT_BITS-1:0]            spec_reg;
    logic [BINS_BITS-1:0]           bins_reg;
    logic [CNT_BITS-1:0]            spd_reg;
    logic [PW-1:0]                  addr_reg;
    logic                           final_reg;
    logic                           lastbin_reg;
    logic signed [SAMPLE_BITS-1:0]  re_reg;
    logic signed [SAMPLE_BITS-1:0]  im_reg;
    logic [ACC_BITS-1:0]            sq_re_reg;
    logic [ACC_BITS-1:0]            sq_im_reg;
    logic                           out_valid_reg;
    logic [OUT_BITS-1:0]            out_word_reg;
    logic                           is_count_reg;
    logic                           last_reg;

    logic                           accept;
    logic [NW-1:0]                  nb_raw;
    logic [NW-1:0]                  nb_eff;
    logic [NW-1:0]                  pos_inc;
    logic                           last_bin;
    logic [CNT_BITS-1:0]            period_eff;
    logic [CNT_BITS:0]              spec_inc;
    logic                           final_spec;
    logic signed [2*SAMPLE_BITS-1:0] sq_re;
    logic signed [2*SAMPLE_BITS-1:0] sq_im;
    logic [ACC_BITS:0]              sum_wide;
    logic [ACC_BITS-1:0]            sum_sat;
    logic                           out_room;
    logic                           out_load;
    logic                           mem_we;
    logic [PW-1:0]                  mem_waddr;
    logic [ACC_BITS-1:0]            mem_wdata;
    logic [ACC_BITS-1:0]            mem_rdata;
    logic                           div_start;
    psi_div_res_t                   div_res;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign nb_raw     = NW'(bins_reg);
    assign nb_eff     = (bins_reg == '0) ? NW'(1) :
                        ((nb_raw > NW'(MAX_BINS)) ? NW'(MAX_BINS) : nb_raw);
    assign pos_inc    = NW'(pos_reg) + NW'(1);
    assign last_bin   = pos_inc >= nb_eff;
    assign period_eff = (spd_reg == '0) ? CNT_BITS'(1) : spd_reg;
    assign spec_inc   = {1'b0, spec_reg} + (CNT_BITS+1)'(1);
    assign final_spec = spec_inc >= {1'b0, period_eff};

    assign sq_re    = re_reg * re_reg;
    assign sq_im    = im_reg * im_reg;
    assign sum_wide = {1'b0, mem_rdata} + {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    assign sum_sat  = sum_wide[ACC_BITS] ? '1 : sum_wide[ACC_BITS-1:0];

    assign out_room  = !out_valid_reg || m_tready;
    assign out_load  = ((state_reg == S_OUT) || (state_reg == S_CNT)) && out_room;
    assign div_start = (state_reg == S_ACC) && final_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
            end
            S_ACC:
            begin
                mem_we    = 1'b1;
                mem_wdata = final_reg ? '0 : sum_sat;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    psi_ram #(
        .WIDTH (ACC_BITS),
        .DEPTH (MAX_BINS)
    ) u_acc_ram (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (accept),
        .rd_addr (pos_reg),
        .rd_data (mem_rdata)
    );

    psi_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_sat),
        .divisor  (period_eff),
        .res      (div_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            pos_reg       <= '0;
            spec_reg      <= '0;
            bins_reg      <= RST_BINS_IN_USE;
            spd_reg       <= RST_SPECTRA_PER_DUMP;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BINS_IN_USE:      bins_reg <= cfg_wdata[BINS_BITS-1:0];
                    REG_SPECTRA_PER_DUMP: spd_reg  <= cfg_wdata;
                    default:              bins_reg <= bins_reg;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + PW'(1);
                    if (clr_reg == PW'(MAX_BINS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_MUL;
                        if (last_bin)
                        begin
                            pos_reg  <= '0;
                            spec_reg <= final_spec ? '0 : spec_inc[CNT_BITS-1:0];
                        end
                        else
                        begin
                            pos_reg <= pos_inc[PW-1:0];
                        end
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= final_reg ? S_DIV : S_IDLE;
                end
                S_DIV:
                begin
                    if (div_res.done)
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_room)
                    begin
                        state_reg <= lastbin_reg ? S_CNT : S_IDLE;
                    end
                end
                S_CNT:
                begin
                    if (out_room)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            re_reg      <= s_tdata[SAMPLE_BITS-1:0];
            im_reg      <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            addr_reg    <= pos_reg;
            final_reg   <= final_spec;
            lastbin_reg <= last_bin;
        end
        if (state_reg == S_MUL)
        begin
            sq_re_reg <= ACC_BITS'($unsigned(sq_re));
            sq_im_reg <= ACC_BITS'($unsigned(sq_im));
        end
        if (state_reg == S_OUT && out_room)
        begin
            out_word_reg <= div_res.quotient;
            is_count_reg <= 1'b0;
            last_reg     <= 1'b0;
        end
        else if (state_reg == S_CNT && out_room)
        begin
            out_word_reg <= OUT_BITS'(period_eff);
            is_count_reg <= 1'b1;
            last_reg     <= 1'b1;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_word_reg;
    assign m_tuser[0] = is_count_reg;
    assign m_tlast    = last_reg;

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        NW'(pos_reg) < NW'(MAX_BINS))
        else $error("bin position beyond store depth");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted while an item is in flight");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> state_reg == S_DIV)
        else $error("divider finished outside the dump path");

    a_count_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("count word without end-of-spectrum mark");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the power spectrum integrator, with a predictor of the bin sums.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import psi_pkg::*;

    localparam int MAX_BINS    = DEF_MAX_BINS;
    localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
    localparam int IDLE_CYCLES = 64;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 350;
    localparam int LONG_PERIOD_ITEMS = 32;
    localparam int MAX_PRINTS  = 40;

    localparam logic [15:0] SMP_MIN = 16'h8000;
    localparam logic [15:0] SMP_MAX = 16'h7FFF;
    localparam longint unsigned ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;

    typedef enum {ROW_CFG, ROW_SAMPLE} row_kind_t;

    typedef struct packed {
        logic [OUT_BITS-1:0] word;
        logic                is_count;
        logic                is_last;
    } power_beat_t;

    typedef struct {
        row_kind_t           kind;
        logic [IDX_BITS-1:0] idx;
        logic [CFG_BITS-1:0] val;
        logic [15:0]         re;
        logic [15:0]         im;
        bit                  typed;
        int                  n_typed;
        logic [OUT_BITS-1:0] avg_word;
        logic [OUT_BITS-1:0] cnt_word;
    } stim_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_BITS-1:0]   m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_we = 1'b0;
    logic [IDX_BITS-1:0]   cfg_index = REG_BINS_IN_USE;
    logic [CFG_BITS-1:0]   cfg_wdata = '0;

    logic [ACC_BITS-1:0]   bin_acc [MAX_BINS];
    logic [9:0]            bin_idx;
    logic [CNT_BITS-1:0]   spec_idx;
    logic [BINS_BITS-1:0]  bins_reg;
    logic [CNT_BITS-1:0]   period_reg;

    power_beat_t           expected_beats [$];
    stim_row_t             directed_rows [$];
    int                    error_count = 0;
    int                    cycle_count = 0;
    bit                    quiet = 1'b0;

    power_spectrum_integrator #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout at cycle %0d", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch %s: got 0x%08h, want 0x%08h, cycle %0d",
                     what, got, want, cycle_count);
    endtask

    // Advance the bin sums by one sample and return the number of beats it yields.
    function automatic int integrate_sample(input logic signed [15:0] re,
                                            input logic signed [15:0] im,
                                            output power_beat_t avg_beat,
                                            output power_beat_t cnt_beat);
        longint          pw;
        longint unsigned nb;
        longint unsigned per;
        longint unsigned sum;
        longint unsigned quot;
        int              pos;
        bit              last_bin;
        bit              final_spec;
        int              n;
        nb = longint'(bins_reg);
        if (nb == 0)
            nb = 1;
        if (nb > MAX_BINS)
            nb = MAX_BINS;
        per = longint'(period_reg);
        if (per == 0)
            per = 1;
        pos = int'(bin_idx);
        last_bin = (longint'(pos) + 1 >= nb);
        final_spec = (longint'(spec_idx) + 1 >= per);
        pw = longint'(re) * longint'(re) + longint'(im) * longint'(im);
        sum = longint'(bin_acc[pos]) + pw;
        if (sum > ACC_MAX)
            sum = ACC_MAX;
        bin_acc[pos] = sum[ACC_BITS-1:0];
        n = 0;
        avg_beat = '0;
        cnt_beat = '0;
        if (final_spec)
        begin
            quot = sum / per;
            if (quot > 64'hFFFF_FFFF)
                quot = 64'hFFFF_FFFF;
            avg_beat.word = quot[OUT_BITS-1:0];
            n = 1;
            bin_acc[pos] = '0;
            if (last_bin)
            begin
                cnt_beat.word = per[OUT_BITS-1:0];
                cnt_beat.is_count = 1'b1;
                cnt_beat.is_last = 1'b1;
                n = 2;
            end
        end
        if (last_bin)
        begin
            bin_idx = '0;
            if (final_spec)
                spec_idx = '0;
            else
                spec_idx = spec_idx + 1'b1;
        end
        else
        begin
            bin_idx = 10'(pos + 1);
        end
        return n;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_component();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0: return SMP_MIN;
            1: return SMP_MAX;
            2: return 16'h0000;
            3: return 16'($urandom_range(0, 31) - 16);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic void add_cfg(input logic [IDX_BITS-1:0] idx,
                                    input logic [CFG_BITS-1:0] val);
        stim_row_t row;
        row = '{ROW_CFG, idx, val, '0, '0, 1'b0, 0, '0, '0};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(input logic [15:0] re, input logic [15:0] im,
                                       input bit typed, input int n_typed,
                                       input logic [31:0] avg_word,
                                       input logic [31:0] cnt_word);
        stim_row_t row;
        row = '{ROW_SAMPLE, REG_BINS_IN_USE, '0, re, im, typed, n_typed, avg_word, cnt_word};
        directed_rows.push_back(row);
    endfunction

    task automatic wait_idle();
        cfg_we <= 1'b0;
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_CYCLES) @(posedge clk);
    endtask

    // Leaves the write enable high so that writes can follow back to back.
    task automatic cfg_write(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        if (idx == REG_BINS_IN_USE)
            bins_reg = val[BINS_BITS-1:0];
        else
            period_reg = val;
    endtask

    task automatic send_sample(input logic [15:0] re, input logic [15:0] im,
                               input bit typed, input int n_typed,
                               input logic [31:0] avg_word, input logic [31:0] cnt_word);
        power_beat_t avg_b;
        power_beat_t cnt_b;
        int          n;
        int          gap;
        cfg_we <= 1'b0;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        n = integrate_sample(re, im, avg_b, cnt_b);
        if (typed)
        begin
            n = n_typed;
            avg_b = '{avg_word, 1'b0, 1'b0};
            cnt_b = '{cnt_word, 1'b1, 1'b1};
        end
        if (n > 0)
            expected_beats.push_back(avg_b);
        if (n > 1)
            expected_beats.push_back(cnt_b);
    endtask

    task automatic run_phase(input logic [15:0] bins_w, input logic [15:0] period_w,
                             input int n_items);
        wait_idle();
        cfg_write(REG_BINS_IN_USE, bins_w);
        cfg_write(REG_SPECTRA_PER_DUMP, period_w);
        quiet = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < n_items; i++)
            send_sample(pick_component(), pick_component(), 1'b0, 0, '0, '0);
        quiet = 1'b0;
    endtask

    initial
    begin : result_sink
        int          ready_run;
        int          stall_run;
        power_beat_t want;
        ready_run = 0;
        stall_run = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid === 1'b1 && m_tready === 1'b1)
            begin
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("beat with nothing expected", m_tdata, '0);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (m_tdata !== want.word)
                        report_mismatch("out_word", m_tdata, want.word);
                    if (m_tuser[0] !== want.is_count)
                        report_mismatch("is_count", 32'(m_tuser[0]), 32'(want.is_count));
                    if (m_tlast !== want.is_last)
                        report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
                end
            end
            if (ready_run == 0 && stall_run == 0)
            begin
                ready_run = $urandom_range(1, 24);
                stall_run = pick_gap();
            end
            if (ready_run > 0)
            begin
                ready_run--;
                m_tready <= 1'b1;
            end
            else
            begin
                stall_run--;
                m_tready <= 1'b0;
            end
        end
    end

    initial
    begin : stimulus
        int          r;
        int          eff_b;
        int          eff_p;
        int          span;
        int          n_items;
        int          random_items;
        logic [15:0] bins_w;
        logic [15:0] period_w;
        stim_row_t   row;

        for (int k = 0; k < MAX_BINS; k++)
            bin_acc[k] = '0;
        bin_idx = '0;
        spec_idx = '0;
        bins_reg = RST_BINS_IN_USE;
        period_reg = RST_SPECTRA_PER_DUMP;

        // reset settings, then zero bin count and zero period
        add_sample(16'd3, 16'd4, 1'b1, 0, '0, '0);
        add_cfg(REG_BINS_IN_USE, 16'd0);
        add_cfg(REG_SPECTRA_PER_DUMP, 16'd0);
        // bin position past the shrunk bin count
        add_sample(SMP_MIN, SMP_MIN, 1'b1, 2, 32'h8000_0000, 32'd1);
        add_sample(SMP_MAX, SMP_MAX, 1'b0, 0, '0, '0);
        add_sample(SMP_MIN, SMP_MAX, 1'b0, 0, '0, '0);
        add_sample(16'd0, 16'd0, 1'b1, 2, 32'd0, 32'd1);
        add_sample(SMP_MAX, SMP_MIN, 1'b0, 0, '0, '0);
        // accumulate, then shrink the period so the average saturates
        add_cfg(REG_SPECTRA_PER_DUMP, 16'd16);
        add_sample(SMP_MIN, SMP_MIN, 1'b1, 0, '0, '0);
        add_sample(SMP_MIN, SMP_MIN, 1'b1, 0, '0, '0);
        add_sample(SMP_MIN, SMP_MIN, 1'b1, 0, '0, '0);
        add_cfg(REG_SPECTRA_PER_DUMP, 16'd1);
        add_sample(SMP_MIN, SMP_MIN, 1'b1, 2, 32'hFFFF_FFFF, 32'd1);
        // bin count above the maximum
        add_cfg(REG_BINS_IN_USE, 16'd2047);
        add_sample(16'd1, 16'd0, 1'b1, 1, 32'd1, '0);
        add_cfg(REG_BINS_IN_USE, 16'd1);
        add_sample(16'd0, 16'd1, 1'b1, 2, 32'd1, 32'd1);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < directed_rows.size(); i++)
        begin
            row = directed_rows[i];
            if (row.kind == ROW_CFG)
            begin
                if (i == 0 || directed_rows[i-1].kind != ROW_CFG)
                    wait_idle();
                cfg_write(row.idx, row.val);
            end
            else
            begin
                send_sample(row.re, row.im, row.typed, row.n_typed, row.avg_word,
                            row.cnt_word);
            end
        end

        // longest period, full scale throughout
        wait_idle();
        cfg_write(REG_BINS_IN_USE, 16'd1);
        cfg_write(REG_SPECTRA_PER_DUMP, 16'hFFFF);
        quiet = 1'b1;
        for (int i = 0; i < LONG_PERIOD_ITEMS; i++)
            send_sample(SMP_MIN, SMP_MIN, 1'b0, 0, '0, '0);
        quiet = 1'b0;

        // one full spectrum at the largest bin count
        run_phase(16'd2047, 16'd1, MAX_BINS);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 60)
                bins_w = 16'($urandom_range(1, 8));
            else if (r < 80)
                bins_w = 16'($urandom_range(9, 32));
            else if (r < 88)
                bins_w = 16'd0;
            else if (r < 94)
                bins_w = ($urandom_range(0, 1) == 0) ? 16'd1024 : 16'($urandom_range(1025, 2047));
            else
                bins_w = 16'($urandom_range(33, 100));
            if ($urandom_range(0, 7) == 0)
                bins_w[15:11] = 5'($urandom_range(1, 31));

            r = $urandom_range(0, 99);
            if (r < 50)
                period_w = 16'($urandom_range(1, 3));
            else if (r < 70)
                period_w = 16'($urandom_range(4, 16));
            else if (r < 80)
                period_w = 16'd0;
            else if (r < 90)
                period_w = 16'($urandom_range(17, 64));
            else
                period_w = 16'($urandom_range(65, 65535));

            eff_b = int'(bins_w[10:0]);
            if (eff_b == 0)
                eff_b = 1;
            if (eff_b > MAX_BINS)
                eff_b = MAX_BINS;
            eff_p = (period_w == 0) ? 1 : int'(period_w);
            span = eff_b * eff_p;
            if (span <= 256)
            begin
                n_items = span * $urandom_range(1, 3);
                if ($urandom_range(0, 4) == 0)
                    n_items += $urandom_range(0, eff_b);
            end
            else
            begin
                n_items = $urandom_range(1, 40);
            end
            run_phase(bins_w, period_w, n_items);
            random_items += n_items;
        end

        wait_idle();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
